### hw/rtl/mpa_pkg.sv
`default_nettype none

package mpa_pkg;

    // Field and register widths fixed by the interface
    localparam int IDX_W      = 13;
    localparam int VAL_W      = 16;
    localparam int SIDE_CFG_W = 6;
    localparam int STEP_W     = 6;
    localparam int WIN_CFG_W  = 3;
    localparam int CHAN_CFG_W = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;

    // Register values after reset
    localparam logic [SIDE_CFG_W-1:0] MAP_SIDE_RST      = 6'd32;
    localparam logic [STEP_W-1:0]     STEP_SIZE_RST     = 6'd2;
    localparam logic [WIN_CFG_W-1:0]  WINDOW_SIDE_RST   = 3'd2;
    localparam logic [CHAN_CFG_W-1:0] CHANNEL_COUNT_RST = 4'd1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_POOL = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_RANGE = 1'b1
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAP_SIDE      = 2'd0,
        REG_STEP_SIZE     = 2'd1,
        REG_WINDOW_SIDE   = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_OSIDE_GO,
        SEQ_OSIDE_WAIT,
        SEQ_AREA,
        SEQ_SQUARE,
        SEQ_COUNT,
        SEQ_CH_GO,
        SEQ_CH_WAIT,
        SEQ_POS_GO,
        SEQ_POS_WAIT,
        SEQ_ROW0,
        SEQ_COL0,
        SEQ_CHBASE,
        SEQ_ROWOFF,
        SEQ_SCAN,
        SEQ_DRAIN,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        cmd_t                     command;
        logic [IDX_W-1:0]         index;
        logic signed [VAL_W-1:0]  sample;
    } mpa_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  peak_value;
        logic [IDX_W-1:0]         peak_index;
        status_t                  status;
    } mpa_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mpa_div.sv
`default_nettype none

module mpa_div import mpa_pkg::*; #(
    parameter int DIV_W = 13
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output div_stat_t             stat,
    output logic [DIV_W-1:0]      quotient,
    output logic [DIV_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // Never restart while a division is still running
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (cnt_reg == '0))
        else $error("divider restarted while busy");

    // Done rises in the cycle after the last iteration
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == CNT_W'(1)) && !start |=> done_reg)
        else $error("divider done missing after last step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (cnt_reg == '0))
        else $error("divider done while still iterating");

endmodule

`default_nettype wire

### hw/rtl/max_pool_with_argmax.sv
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------
// s_       | in        | s_valid / s_ready    | s_data : command, index, sample
// m_       | out       | m_valid / m_ready    | m_data : peak_value, peak_index, status
// cfg_     | in        | cfg_wr_en (no wait)  | cfg_addr, cfg_wr_data
//
// A load transfer writes the feature map directly.
// A pool transfer runs up to three divisions through one shared radix-2 divider and
// up to seven steps through one shared multiplier, then one map read per window
// cell that lies inside the map.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next transfer is taken while it waits.
// Reset is synchronous on aresetn; the feature map itself is not cleared.

module max_pool_with_argmax import mpa_pkg::*; #(
    parameter int MAX_SIDE     = 32,
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WINDOW   = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mpa_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mpa_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int AREA_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int PROD_W    = ADDR_W + 1;
    localparam int B_W0      = (SIDE_W > CH_W) ? SIDE_W : CH_W;
    localparam int B_W       = (B_W0 > STEP_W) ? B_W0 : STEP_W;
    localparam int DIV_W     = (IDX_W > AREA_W) ? IDX_W : AREA_W;
    localparam int CRD_W     = ((SIDE_W > WIN_W) ? SIDE_W : WIN_W) + 1;
    localparam int CMP_W     = (PROD_W > IDX_W) ? PROD_W : IDX_W;

    // Configuration registers
    logic [SIDE_CFG_W-1:0] map_side_reg;
    logic [STEP_W-1:0]     step_size_reg;
    logic [WIN_CFG_W-1:0]  window_side_reg;
    logic [CHAN_CFG_W-1:0] channel_count_reg;

    logic [SIDE_W-1:0] side_c;
    logic [STEP_W-1:0] step_c;
    logic [WIN_W-1:0]  win_c;
    logic [CH_W-1:0]   chans_c;

    // Sequencer and datapath
    seq_state_t state_reg, state_next;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SIDE_W-1:0]       oside_reg, oside_next;
    logic [AREA_W-1:0]       oarea_reg, oarea_next;
    logic [AREA_W-1:0]       side2_reg, side2_next;
    logic [PROD_W-1:0]       ocount_reg, ocount_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [SIDE_W-1:0]       orow_reg, orow_next;
    logic [SIDE_W-1:0]       ocol_reg, ocol_next;
    logic [SIDE_W-1:0]       y0_reg, y0_next;
    logic [SIDE_W-1:0]       x0_reg, x0_next;
    logic [ADDR_W-1:0]       chbase_reg, chbase_next;
    logic [ADDR_W-1:0]       row_addr_reg, row_addr_next;
    logic [WIN_W-1:0]        p_reg, p_next;
    logic [WIN_W-1:0]        q_reg, q_next;
    logic signed [VAL_W-1:0] best_val_reg, best_val_next;
    logic [ADDR_W-1:0]       best_at_reg, best_at_next;
    logic                    have_reg, have_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]       rd_at_reg, rd_at_next;
    logic                    oor_reg, oor_next;
    logic                    m_valid_reg, m_valid_next;
    mpa_out_t                m_data_reg, m_data_next;

    // Control from the output decoder
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    div_stat_t         div_stat;
    logic [DIV_W-1:0]  div_quo;
    logic [DIV_W-1:0]  div_rem;
    logic [PROD_W-1:0] mul_a;
    logic [B_W-1:0]    mul_b;
    logic [PROD_W+B_W-1:0] mul_full;
    logic [PROD_W-1:0] mul_p;
    logic              out_load;
    logic              in_accept;
    logic              load_en;
    logic              rd_en;

    // Window scan helpers
    logic [CRD_W-1:0]  cur_y, cur_x;
    logic              in_map;
    logic [ADDR_W-1:0] cur_addr;
    logic [WIN_W-1:0]  win_last;
    logic              last_q, last_p;
    logic              in_range;

    // Feature map
    logic [VAL_W-1:0]  map_mem [MAP_DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;

    // Clamp register values into their legal range
    always_comb begin
        if (map_side_reg == '0) begin
            side_c = SIDE_W'(1);
        end else if (int'(map_side_reg) > MAX_SIDE) begin
            side_c = SIDE_W'(MAX_SIDE);
        end else begin
            side_c = SIDE_W'(map_side_reg);
        end
        step_c = (step_size_reg == '0) ? STEP_W'(1) : step_size_reg;
        if (window_side_reg == '0) begin
            win_c = WIN_W'(1);
        end else if (int'(window_side_reg) > MAX_WINDOW) begin
            win_c = WIN_W'(MAX_WINDOW);
        end else begin
            win_c = WIN_W'(window_side_reg);
        end
        if (channel_count_reg == '0) begin
            chans_c = CH_W'(1);
        end else if (int'(channel_count_reg) > MAX_CHANNELS) begin
            chans_c = CH_W'(MAX_CHANNELS);
        end else begin
            chans_c = CH_W'(channel_count_reg);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_side_reg      <= MAP_SIDE_RST;
            step_size_reg     <= STEP_SIZE_RST;
            window_side_reg   <= WINDOW_SIDE_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MAP_SIDE:      map_side_reg      <= cfg_wr_data[SIDE_CFG_W-1:0];
                REG_STEP_SIZE:     step_size_reg     <= cfg_wr_data[STEP_W-1:0];
                REG_WINDOW_SIDE:   window_side_reg   <= cfg_wr_data[WIN_CFG_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wr_data[CHAN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared divider
    mpa_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Shared multiplier
    assign mul_full = {{B_W{1'b0}}, mul_a} * {{PROD_W{1'b0}}, mul_b};
    assign mul_p    = mul_full[PROD_W-1:0];

    // Window position and bounds
    assign cur_y    = CRD_W'(y0_reg) + CRD_W'(p_reg);
    assign cur_x    = CRD_W'(x0_reg) + CRD_W'(q_reg);
    assign in_map   = (cur_y < CRD_W'(side_c)) && (cur_x < CRD_W'(side_c));
    assign cur_addr = row_addr_reg + ADDR_W'(q_reg);
    assign win_last = win_c - 1'b1;
    assign last_q   = (q_reg == win_last);
    assign last_p   = (p_reg == win_last);
    assign in_range = (CMP_W'(idx_reg) < CMP_W'(ocount_reg));

    assign in_accept = s_valid && s_ready;
    assign load_en   = in_accept && (s_data.command == CMD_LOAD)
                       && (int'(s_data.index) < MAP_DEPTH);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_valid && (s_data.command == CMD_POOL)) begin
                    state_next = SEQ_OSIDE_GO;
                end
            end
            SEQ_OSIDE_GO:   state_next = SEQ_OSIDE_WAIT;
            SEQ_OSIDE_WAIT: if (div_stat.done) state_next = SEQ_AREA;
            SEQ_AREA:       state_next = SEQ_SQUARE;
            SEQ_SQUARE:     state_next = SEQ_COUNT;
            SEQ_COUNT:      state_next = SEQ_CH_GO;
            SEQ_CH_GO:      state_next = in_range ? SEQ_CH_WAIT : SEQ_FINISH;
            SEQ_CH_WAIT:    if (div_stat.done) state_next = SEQ_POS_GO;
            SEQ_POS_GO:     state_next = SEQ_POS_WAIT;
            SEQ_POS_WAIT:   if (div_stat.done) state_next = SEQ_ROW0;
            SEQ_ROW0:       state_next = SEQ_COL0;
            SEQ_COL0:       state_next = SEQ_CHBASE;
            SEQ_CHBASE:     state_next = SEQ_ROWOFF;
            SEQ_ROWOFF:     state_next = SEQ_SCAN;
            SEQ_SCAN:       if (last_q && last_p) state_next = SEQ_DRAIN;
            SEQ_DRAIN:      state_next = SEQ_FINISH;
            SEQ_FINISH:     if (!m_valid_reg || m_ready) state_next = SEQ_IDLE;
            default:        state_next = SEQ_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = '0;
        mul_b        = '0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: s_ready = 1'b1;
            SEQ_OSIDE_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(side_c - 1'b1);
                div_divisor  = DIV_W'(step_c);
            end
            SEQ_AREA: begin
                mul_a = PROD_W'(oside_reg);
                mul_b = B_W'(oside_reg);
            end
            SEQ_SQUARE: begin
                mul_a = PROD_W'(side_c);
                mul_b = B_W'(side_c);
            end
            SEQ_COUNT: begin
                mul_a = PROD_W'(oarea_reg);
                mul_b = B_W'(chans_c);
            end
            SEQ_CH_GO: begin
                div_start    = in_range;
                div_dividend = DIV_W'(idx_reg);
                div_divisor  = DIV_W'(oarea_reg);
            end
            SEQ_POS_GO: begin
                div_start    = 1'b1;
                div_dividend = div_rem;
                div_divisor  = DIV_W'(oside_reg);
            end
            SEQ_ROW0: begin
                mul_a = PROD_W'(orow_reg);
                mul_b = B_W'(step_c);
            end
            SEQ_COL0: begin
                mul_a = PROD_W'(ocol_reg);
                mul_b = B_W'(step_c);
            end
            SEQ_CHBASE: begin
                mul_a = PROD_W'(side2_reg);
                mul_b = B_W'(ch_reg);
            end
            SEQ_ROWOFF: begin
                mul_a = PROD_W'(y0_reg);
                mul_b = B_W'(side_c);
            end
            SEQ_SCAN:   rd_en = in_map;
            SEQ_FINISH: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        idx_next      = idx_reg;
        oside_next    = oside_reg;
        oarea_next    = oarea_reg;
        side2_next    = side2_reg;
        ocount_next   = ocount_reg;
        ch_next       = ch_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        y0_next       = y0_reg;
        x0_next       = x0_reg;
        chbase_next   = chbase_reg;
        row_addr_next = row_addr_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        best_val_next = best_val_reg;
        best_at_next  = best_at_reg;
        have_next     = have_reg;
        rd_pend_next  = 1'b0;
        rd_at_next    = rd_at_reg;
        oor_next      = oor_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        // Fold the element read last cycle into the running maximum
        if (rd_pend_reg && (!have_reg || ($signed(rd_data_reg) > best_val_reg))) begin
            have_next     = 1'b1;
            best_val_next = $signed(rd_data_reg);
            best_at_next  = rd_at_reg;
        end

        case (state_reg)
            SEQ_IDLE: begin
                idx_next = s_data.index;
                oor_next = 1'b0;
            end
            SEQ_OSIDE_WAIT: oside_next  = SIDE_W'(div_quo) + 1'b1;
            SEQ_AREA:       oarea_next  = AREA_W'(mul_p);
            SEQ_SQUARE:     side2_next  = AREA_W'(mul_p);
            SEQ_COUNT:      ocount_next = mul_p;
            SEQ_CH_GO:      oor_next    = !in_range;
            SEQ_CH_WAIT:    ch_next     = CH_W'(div_quo);
            SEQ_POS_WAIT: begin
                orow_next = SIDE_W'(div_quo);
                ocol_next = SIDE_W'(div_rem);
            end
            SEQ_ROW0:   y0_next = SIDE_W'(mul_p);
            SEQ_COL0:   x0_next = SIDE_W'(mul_p);
            SEQ_CHBASE: chbase_next = ADDR_W'(mul_p) + ADDR_W'(x0_reg);
            SEQ_ROWOFF: begin
                row_addr_next = ADDR_W'(mul_p) + chbase_reg;
                p_next        = '0;
                q_next        = '0;
                have_next     = 1'b0;
            end
            SEQ_SCAN: begin
                rd_pend_next = in_map;
                rd_at_next   = cur_addr;
                if (last_q) begin
                    q_next        = '0;
                    p_next        = p_reg + 1'b1;
                    row_addr_next = row_addr_reg + ADDR_W'(side_c);
                end else begin
                    q_next = q_reg + 1'b1;
                end
            end
            default: ;
        endcase

        // Output register: hold until taken, load when free
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            if (oor_reg) begin
                m_data_next.peak_value = '0;
                m_data_next.peak_index = '0;
                m_data_next.status     = STATUS_RANGE;
            end else begin
                m_data_next.peak_value = best_val_reg;
                m_data_next.peak_index = IDX_W'(best_at_reg);
                m_data_next.status     = STATUS_OK;
            end
        end
    end

    // Control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            have_reg    <= 1'b0;
            oor_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
            have_reg    <= have_next;
            oor_reg     <= oor_next;
        end
        idx_reg      <= idx_next;
        oside_reg    <= oside_next;
        oarea_reg    <= oarea_next;
        side2_reg    <= side2_next;
        ocount_reg   <= ocount_next;
        ch_reg       <= ch_next;
        orow_reg     <= orow_next;
        ocol_reg     <= ocol_next;
        y0_reg       <= y0_next;
        x0_reg       <= x0_next;
        chbase_reg   <= chbase_next;
        row_addr_reg <= row_addr_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        best_val_reg <= best_val_next;
        best_at_reg  <= best_at_next;
        rd_at_reg    <= rd_at_next;
        m_data_reg   <= m_data_next;
    end

    // Feature map write port
    always_ff @(posedge aclk) begin
        if (load_en) begin
            map_mem[ADDR_W'(s_data.index)] <= s_data.sample;
        end
    end

    // Feature map read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= map_mem[cur_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten");

    // A pool transfer blocks further input while it is worked on
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (s_data.command == CMD_POOL) |=> !s_ready)
        else $error("input taken during pool work");

    // An in-range window always contains at least one map element
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_FINISH) && !oor_reg |-> have_reg)
        else $error("window finished with no element");

    // The divider is only started when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire
